// File: hdl/assert_macros.svh
// Assertion macros used by the top level of the lyrics time tag parser.
// Plain text macros, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lrctt_pkg.sv
// Package for the lyrics time tag parser: parse phases, tag kinds,
// the running parse state record and its reset value. No dependencies.
package lrctt_pkg;

  typedef enum logic [2:0] {
    PH_MIN     = 3'd0,
    PH_SEC     = 3'd1,
    PH_FRAC    = 3'd2,
    PH_BAD     = 3'd3,
    PH_OFS_WS  = 3'd4,
    PH_OFS_DIG = 3'd5,
    PH_OFS_END = 3'd6
  } phase_t;

  localparam logic [1:0] KIND_TIME    = 2'd0;
  localparam logic [1:0] KIND_ID      = 2'd1;
  localparam logic [1:0] KIND_OFFSET  = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  // candidate bits: 0 "ti:", 1 "ar:", 2 "offset:"
  localparam logic [2:0] CAND_ALL = 3'b111;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  digit_count;
    logic [6:0]  minute_value;
    logic [6:0]  second_value;
    logic [9:0]  fraction_value;
    logic [2:0]  prefix_position;
    logic [2:0]  prefix_candidates;
    logic        offset_sign;
    logic [31:0] offset_accumulator;
  } tag_state_t;

  localparam tag_state_t STATE_RESET = '{
    phase:              PH_MIN,
    digit_count:        2'd0,
    minute_value:       7'd0,
    second_value:       7'd0,
    fraction_value:     10'd0,
    prefix_position:    3'd0,
    prefix_candidates:  CAND_ALL,
    offset_sign:        1'b0,
    offset_accumulator: 32'd0
  };

endpackage

// File: hdl/lrctt_state.sv
// Running parse state of the tag parser: per-character update and register.
// Depends on lrctt_pkg.
module lrctt_state (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 tag_end,
  input  logic [7:0]           char_code,
  output lrctt_pkg::tag_state_t state
);
  import lrctt_pkg::*;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;

  function automatic logic [7:0] ti_char(input logic [1:0] pos);
    case (pos)
      2'd0:    ti_char = 8'h74; // t
      2'd1:    ti_char = 8'h69; // i
      default: ti_char = CH_COLON;
    endcase
  endfunction

  function automatic logic [7:0] ar_char(input logic [1:0] pos);
    case (pos)
      2'd0:    ar_char = 8'h61; // a
      2'd1:    ar_char = 8'h72; // r
      default: ar_char = CH_COLON;
    endcase
  endfunction

  function automatic logic [7:0] ofs_char(input logic [2:0] pos);
    case (pos)
      3'd0:    ofs_char = 8'h6F; // o
      3'd1:    ofs_char = 8'h66; // f
      3'd2:    ofs_char = 8'h66; // f
      3'd3:    ofs_char = 8'h73; // s
      3'd4:    ofs_char = 8'h65; // e
      3'd5:    ofs_char = 8'h74; // t
      default: ofs_char = CH_COLON;
    endcase
  endfunction

  tag_state_t  state_next;
  logic        is_dig;
  logic [3:0]  dval;
  logic [35:0] acc_scaled;
  logic [2:0]  pos_inc;

  always_comb begin
    state_next = state;
    is_dig     = char_code inside {[8'h30:8'h39]};
    dval       = is_dig ? 4'(char_code - CH_ZERO) : 4'd0;
    acc_scaled = {1'b0, state.offset_accumulator, 3'b000}
                 + {3'b000, state.offset_accumulator, 1'b0}
                 + 36'(dval);
    pos_inc    = state.prefix_position + 3'd1;

    // time / offset field parsing
    case (state.phase)
      PH_MIN: begin
        if (is_dig && state.digit_count < 2'd2) begin
          state_next.minute_value = 7'(11'(state.minute_value) * 11'd10 + 11'(dval));
          state_next.digit_count  = state.digit_count + 2'd1;
        end else if (char_code == CH_COLON && state.digit_count != 2'd0) begin
          state_next.phase       = PH_SEC;
          state_next.digit_count = 2'd0;
        end else begin
          state_next.phase = PH_BAD;
        end
      end
      PH_SEC: begin
        if (is_dig && state.digit_count < 2'd2) begin
          state_next.second_value = 7'(11'(state.second_value) * 11'd10 + 11'(dval));
          state_next.digit_count  = state.digit_count + 2'd1;
        end else if ((char_code == CH_DOT || char_code == CH_COLON)
                     && state.digit_count == 2'd2) begin
          state_next.phase       = PH_FRAC;
          state_next.digit_count = 2'd0;
        end else begin
          state_next.phase = PH_BAD;
        end
      end
      PH_FRAC: begin
        if (is_dig && state.digit_count < 2'd3) begin
          state_next.fraction_value = 10'(14'(state.fraction_value) * 14'd10 + 14'(dval));
          state_next.digit_count    = state.digit_count + 2'd1;
        end else begin
          state_next.phase = PH_BAD;
        end
      end
      PH_OFS_WS: begin
        if (char_code == CH_SPACE || char_code inside {[8'h09:8'h0D]}) begin
          state_next.phase = PH_OFS_WS;
        end else if (char_code == CH_PLUS || char_code == CH_MINUS) begin
          state_next.offset_sign = (char_code == CH_MINUS);
          state_next.phase       = PH_OFS_DIG;
        end else if (is_dig) begin
          state_next.offset_accumulator = 32'(dval);
          state_next.phase              = PH_OFS_DIG;
        end else begin
          state_next.phase = PH_OFS_END;
        end
      end
      PH_OFS_DIG: begin
        if (is_dig) begin
          // magnitude saturates at 2^31
          state_next.offset_accumulator = (acc_scaled > MAG_LIMIT) ?
                                          MAG_LIMIT[31:0] : acc_scaled[31:0];
        end else begin
          state_next.phase = PH_OFS_END;
        end
      end
      default: begin
        state_next.phase = state.phase;
      end
    endcase

    // prefix matching, first seven characters
    if (state.prefix_position != 3'd7) begin
      if (state.prefix_position < 3'd3 && char_code != ti_char(state.prefix_position[1:0]))
        state_next.prefix_candidates[0] = 1'b0;
      if (state.prefix_position < 3'd3 && char_code != ar_char(state.prefix_position[1:0]))
        state_next.prefix_candidates[1] = 1'b0;
      if (char_code != ofs_char(state.prefix_position))
        state_next.prefix_candidates[2] = 1'b0;
      state_next.prefix_position = pos_inc;
      if (pos_inc == 3'd7 && state_next.prefix_candidates[2]) begin
        state_next.phase              = PH_OFS_WS;
        state_next.offset_sign        = 1'b0;
        state_next.offset_accumulator = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (step) begin
      state <= tag_end ? STATE_RESET : state_next;
    end
  end

endmodule

// File: hdl/lrctt_result.sv
// End-of-tag classification and value assembly from the parse state.
// Depends on lrctt_pkg.
module lrctt_result (
  input  lrctt_pkg::tag_state_t state,
  input  logic                  allow_id_tags,
  output logic [1:0]            tag_kind,
  output logic [22:0]           time_ms,
  output logic signed [31:0]    offset_ms
);
  import lrctt_pkg::*;

  localparam logic [22:0] MS_PER_MIN = 23'd60000;
  localparam logic [22:0] MS_PER_SEC = 23'd1000;
  localparam logic [31:0] POS_MAX    = 32'h7FFF_FFFF;

  logic        id_hit;
  logic        ofs_hit;
  logic        time_hit;
  logic [22:0] frac_ms;

  always_comb begin
    id_hit   = allow_id_tags && state.prefix_position >= 3'd3
               && state.prefix_candidates[1:0] != 2'b00;
    ofs_hit  = allow_id_tags && state.prefix_position == 3'd7 && state.prefix_candidates[2];
    time_hit = (state.phase == PH_SEC && state.digit_count == 2'd2)
               || (state.phase == PH_FRAC && state.digit_count >= 2'd2);
    // two fraction digits are hundredths
    frac_ms  = (state.digit_count == 2'd3) ? 23'(state.fraction_value)
                                           : 23'(state.fraction_value) * 23'd10;

    tag_kind  = KIND_INVALID;
    time_ms   = 23'd0;
    offset_ms = 32'sd0;
    if (id_hit) begin
      tag_kind = KIND_ID;
    end else if (ofs_hit) begin
      tag_kind = KIND_OFFSET;
      if (state.offset_sign)
        offset_ms = $signed(32'd0 - state.offset_accumulator);
      else
        offset_ms = $signed((state.offset_accumulator > POS_MAX) ? POS_MAX
                                                                 : state.offset_accumulator);
    end else if (time_hit) begin
      tag_kind = KIND_TIME;
      time_ms  = 23'(state.minute_value) * MS_PER_MIN + 23'(state.second_value) * MS_PER_SEC
                 + ((state.phase == PH_FRAC) ? frac_ms : 23'd0);
    end
  end

endmodule

// File: hdl/lrc_time_tag_parser_core.sv
// Top level of the lyrics time tag parser: input register, parse state,
// result register. Depends on lrctt_pkg, lrctt_state, lrctt_result, assert_macros.svh.
//
// Usage notes:
//  - Item channel (item_valid / item_stall): one transfer per tag character
//    (action = 0) or one end-of-tag marker (action = 1). allow_id_tags only
//    matters on the end-of-tag transfer.
//  - Result channel (result_valid / result_stall): one transfer per end of
//    tag carrying tag_kind, time_ms and offset_ms. Character transfers
//    produce nothing.
//  - Result path: an end-of-tag transfer passes the input register, then
//    the result register, whose output is result_valid.
//  - Throughput: one item per cycle while item_stall is low; the per-character update
//    and the end-of-tag arithmetic each fit in the single stage between registers.
//  - Stall: while result_stall holds a pending result, character items keep
//    flowing; an end-of-tag item parks in the input register and item_stall
//    rises until the result register is free.
//  - Reset (rst, synchronous): drops both stages and returns the parse state
//    to the start of a tag. Each end of tag also restores that state.
module lrc_time_tag_parser_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               action,
  input  logic [7:0]         char_code,
  input  logic               allow_id_tags,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         tag_kind,
  output logic [22:0]        time_ms,
  output logic signed [31:0] offset_ms
);
  import lrctt_pkg::*;
  `include "assert_macros.svh"

  // input register
  logic       s1_valid;
  logic       s1_action;
  logic [7:0] s1_char;
  logic       s1_allow;

  logic s1_blocked;
  logic s1_fire;
  logic item_take;
  logic result_load;

  tag_state_t             tag_state;
  logic [1:0]             kind_calc;
  logic [22:0]            time_calc;
  logic signed [31:0]     offset_calc;

  // assertion helpers
  logic res_time_clean;
  logic res_ofs_clean;
  logic end_parked;
  logic state_clear;

  // only an end of tag needs the result register
  assign s1_blocked  = s1_action && result_valid && result_stall;
  assign s1_fire     = s1_valid && !s1_blocked;
  assign item_stall  = s1_valid && s1_blocked;
  assign item_take   = item_valid && !item_stall;
  assign result_load = s1_fire && s1_action;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_action <= action;
      s1_char   <= char_code;
      s1_allow  <= allow_id_tags;
    end
  end

  lrctt_state u_state (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_fire),
    .tag_end   (s1_action),
    .char_code (s1_char),
    .state     (tag_state)
  );

  lrctt_result u_result (
    .state         (tag_state),
    .allow_id_tags (s1_allow),
    .tag_kind      (kind_calc),
    .time_ms       (time_calc),
    .offset_ms     (offset_calc)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      tag_kind  <= kind_calc;
      time_ms   <= time_calc;
      offset_ms <= offset_calc;
    end
  end

  assign res_time_clean = (tag_kind == KIND_TIME) || (time_ms == 23'd0);
  assign res_ofs_clean  = (tag_kind == KIND_OFFSET) || (offset_ms == 32'sd0);
  assign end_parked     = s1_valid && s1_action && result_valid;
  assign state_clear    = tag_state.phase == PH_MIN && tag_state.prefix_candidates == CAND_ALL
                          && tag_state.prefix_position == 3'd0;

  `ASSERT_IMPL(a_time_zero, clk, rst, result_valid, res_time_clean, "time_ms on non-time tag")
  `ASSERT_IMPL(a_offset_zero, clk, rst, result_valid, res_ofs_clean, "offset_ms on other tag")
  `ASSERT_IMPL(a_stall_cause, clk, rst, item_stall, end_parked, "stall without parked end")
  `ASSERT_NEXT(a_end_clears, clk, rst, result_load, state_clear, "no clear after end of tag")

endmodule
